### rtl/cxpc_pkg.sv
// Shared types and constants for the chained XOR packet cipher.
// No dependencies; imported by the core and the top level.
`default_nettype none

package cxpc_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_KEY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 2'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic [7:0] random_key;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_packet;
        logic       checksum_ok;
    } t_result;

    typedef struct packed {
        logic [7:0] fixed_key;
        logic       decrypt_mode;
    } t_cfg;

endpackage

`default_nettype wire

### rtl/cxpc_core.sv
// Chain state registers and the per-byte two-stage XOR datapath.
// Depends on cxpc_pkg for item, result and configuration types.
`default_nettype none

module cxpc_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire cxpc_pkg::t_in_item i_item,
    input  wire cxpc_pkg::t_cfg    i_cfg,
    output cxpc_pkg::t_result      o_result
);
    import cxpc_pkg::*;

    logic [7:0] r_prev_cipher, n_prev_cipher;
    logic [7:0] r_prev_middle, n_prev_middle;
    logic [7:0] r_position, n_position;
    logic [7:0] r_rkey, n_rkey;
    logic [7:0] r_checksum, n_checksum;
    logic [7:0] r_sum, n_sum;

    logic [7:0] cur_cipher, cur_middle, cur_position, cur_rkey, cur_sum;
    logic [7:0] pad_mid, pad_ciph, middle, cipher, plain;

    always_comb begin
        // restart the chain on the checksum byte
        cur_cipher   = i_item.first_byte ? 8'd0 : r_prev_cipher;
        cur_middle   = i_item.first_byte ? 8'd0 : r_prev_middle;
        cur_position = i_item.first_byte ? 8'd0 : r_position;
        cur_sum      = i_item.first_byte ? 8'd0 : r_sum;
        cur_rkey     = i_item.first_byte ? i_item.random_key : r_rkey;

        pad_mid  = cur_middle + cur_rkey + cur_position + 8'd1;
        pad_ciph = cur_cipher + i_cfg.fixed_key + cur_position + 8'd1;

        if (i_cfg.decrypt_mode) begin
            cipher = i_item.data_byte;
            middle = cipher ^ pad_ciph;
            plain  = middle ^ pad_mid;
        end else begin
            plain  = i_item.data_byte;
            middle = plain ^ pad_mid;
            cipher = middle ^ pad_ciph;
        end

        n_checksum    = i_item.first_byte ? plain : r_checksum;
        n_sum         = i_item.first_byte ? cur_sum : cur_sum + plain;
        n_prev_cipher = cipher;
        n_prev_middle = middle;
        n_position    = cur_position + 8'd1;
        n_rkey        = cur_rkey;

        o_result.out_byte      = i_cfg.decrypt_mode ? plain : cipher;
        o_result.end_of_packet = i_item.last_byte;
        o_result.checksum_ok   = (i_item.last_byte && i_cfg.decrypt_mode) ?
                                 (n_sum == n_checksum) : 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_cipher <= 8'd0;
            r_prev_middle <= 8'd0;
            r_position    <= 8'd0;
            r_rkey        <= 8'd0;
            r_checksum    <= 8'd0;
            r_sum         <= 8'd0;
        end else if (i_advance) begin
            r_prev_cipher <= n_prev_cipher;
            r_prev_middle <= n_prev_middle;
            r_position    <= n_position;
            r_rkey        <= n_rkey;
            r_checksum    <= n_checksum;
            r_sum         <= n_sum;
        end
    end

    property p_first_sets_position;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_advance && i_item.first_byte) |=> (r_position == 8'd1);
    endproperty
    a_first_sets_position: assert property (p_first_sets_position)
        else $error("position not restarted by checksum byte");

    property p_bad_checksum_only_on_last;
        @(posedge i_clk) disable iff (!i_rst_n)
            !o_result.checksum_ok |-> (i_item.last_byte && i_cfg.decrypt_mode);
    endproperty
    a_bad_checksum_only_on_last: assert property (p_bad_checksum_only_on_last)
        else $error("checksum flag dropped outside last decrypted byte");

endmodule

`default_nettype wire

### rtl/chained_xor_packet_cipher_top.sv
// Top level of the chained XOR packet cipher: config registers,
// input handshake and result register. Depends on cxpc_pkg and cxpc_core.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_ready    data_byte first_byte last_byte random_key
//   result    out        o_out_valid / i_out_ready  out_byte end_of_packet checksum_ok
//   config    in         i_cfg_we                   i_cfg_index i_cfg_data
//
// One byte per cycle while the result is not stalled; the result is registered and
// appears in the cycle after its transfer, from the single result register behind the 8-bit add/XOR chain.
// Synchronous active-low reset clears chain state, config and result valid.
// A stalled result holds; a new byte is taken in the cycle the result leaves.
`default_nettype none

module chained_xor_packet_cipher_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [cxpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cxpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic                          i_first_byte,
    input  wire logic                          i_last_byte,
    input  wire logic [7:0]                    i_random_key,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [7:0]                         o_out_byte,
    output logic                               o_end_of_packet,
    output logic                               o_checksum_ok
);
    import cxpc_pkg::*;

    t_cfg     r_cfg;
    t_in_item in_item;
    t_result  core_result;
    t_result  r_result;
    logic     r_out_valid;
    logic     in_xfer;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign in_item.data_byte  = i_data_byte;
    assign in_item.first_byte = i_first_byte;
    assign in_item.last_byte  = i_last_byte;
    assign in_item.random_key = i_random_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIXED_KEY:    r_cfg.fixed_key    <= i_cfg_data[7:0];
                CFG_DECRYPT_MODE: r_cfg.decrypt_mode <= i_cfg_data[0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    cxpc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (in_xfer),
        .i_item    (in_item),
        .i_cfg     (r_cfg),
        .o_result  (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_result.out_byte;
    assign o_end_of_packet = r_result.end_of_packet;
    assign o_checksum_ok   = r_result.checksum_ok;

    property p_xfer_gives_result;
        @(posedge i_clk) disable iff (!i_rst_n)
            in_xfer |=> o_out_valid;
    endproperty
    a_xfer_gives_result: assert property (p_xfer_gives_result)
        else $error("transfer did not produce a result");

    property p_stall_holds_result;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(r_result));
    endproperty
    a_stall_holds_result: assert property (p_stall_holds_result)
        else $error("stalled result changed");

    property p_bad_checksum_on_eop;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_out_valid && !o_checksum_ok) |-> o_end_of_packet;
    endproperty
    a_bad_checksum_on_eop: assert property (p_bad_checksum_on_eop)
        else $error("checksum failure flagged before end of packet");

endmodule

`default_nettype wire
